// ===== rtl/kmj_pkg.sv =====
// Package for the keyboard matrix and joystick ports: codes, payload types, key map.
package kmj_pkg;

    // Default number of key matrix rows
    localparam int KMJ_KEY_ROWS = 6;

    localparam logic [7:0] PORT_IDLE = 8'hFF;

    // Operation codes
    typedef enum logic [2:0] {
        OP_SET_KEY   = 3'd0,
        OP_SET_CHAR  = 3'd1,
        OP_LOAD_PORT = 3'd2,
        OP_SET_BIT   = 3'd3,
        OP_BUS_READ  = 3'd4,
        OP_P2_READ   = 3'd5
    } t_kmj_op;

    // Command payload
    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] key_row;
        logic [7:0] key_column;
        logic [7:0] char_code;
        logic       pressed;
        logic       port_select;
        logic [7:0] port_value;
        logic [2:0] bit_index;
        logic [7:0] p1_value;
        logic [7:0] p2_value;
    } t_kmj_cmd;

    // Key position decoded from a character
    typedef struct packed {
        logic       hit;
        logic [2:0] row;
        logic [2:0] col;
    } t_kmj_key;

    // Case-insensitive ASCII to key position map
    function automatic t_kmj_key kmj_char_key(input logic [7:0] code);
        logic [7:0] c;
        logic [5:0] k;
        t_kmj_key   key;
        c = code;
        // fold lower case onto upper case
        if (c >= 8'h61 && c <= 8'h7A) begin
            c = c - 8'h20;
        end
        key.hit = 1'b1;
        k       = '0;
        unique case (c) inside
            [8'h30:8'h39]: k = 6'(c - 8'h30);
            8'h20:         k = {3'd1, 3'd4};
            8'h3F:         k = {3'd1, 3'd5};
            8'h4C:         k = {3'd1, 3'd6};
            8'h50:         k = {3'd1, 3'd7};
            8'h2B:         k = {3'd2, 3'd0};
            8'h57:         k = {3'd2, 3'd1};
            8'h45:         k = {3'd2, 3'd2};
            8'h52:         k = {3'd2, 3'd3};
            8'h54:         k = {3'd2, 3'd4};
            8'h55:         k = {3'd2, 3'd5};
            8'h49:         k = {3'd2, 3'd6};
            8'h4F:         k = {3'd2, 3'd7};
            8'h51:         k = {3'd3, 3'd0};
            8'h53:         k = {3'd3, 3'd1};
            8'h44:         k = {3'd3, 3'd2};
            8'h46:         k = {3'd3, 3'd3};
            8'h47:         k = {3'd3, 3'd4};
            8'h48:         k = {3'd3, 3'd5};
            8'h4A:         k = {3'd3, 3'd6};
            8'h4B:         k = {3'd3, 3'd7};
            8'h41:         k = {3'd4, 3'd0};
            8'h5A:         k = {3'd4, 3'd1};
            8'h58:         k = {3'd4, 3'd2};
            8'h43:         k = {3'd4, 3'd3};
            8'h56:         k = {3'd4, 3'd4};
            8'h42:         k = {3'd4, 3'd5};
            8'h4D:         k = {3'd4, 3'd6};
            8'h2E:         k = {3'd4, 3'd7};
            8'h2D:         k = {3'd5, 3'd0};
            8'h2A:         k = {3'd5, 3'd1};
            8'h2F:         k = {3'd5, 3'd2};
            8'h3D:         k = {3'd5, 3'd3};
            8'h59:         k = {3'd5, 3'd4};
            8'h4E:         k = {3'd5, 3'd5};
            8'h7F:         k = {3'd5, 3'd6};
            8'h0A, 8'h0D:  k = {3'd5, 3'd7};
            default:       key.hit = 1'b0;
        endcase
        key.row = k[5:3];
        key.col = k[2:0];
        return key;
    endfunction

endpackage

// ===== rtl/kmj_if.sv =====
// Valid/ready channel interfaces for commands and read responses.
interface kmj_cmd_if;
    logic              valid;
    logic              ready;
    kmj_pkg::t_kmj_cmd payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface kmj_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;

    modport source (output valid, output read_data, input ready);
    modport sink   (input valid, input read_data, output ready);
endinterface

// ===== rtl/kmj_read.sv =====
// Read path: joystick bus read and priority-encoded keyboard row scan.
module kmj_read #(
    parameter int KEY_ROWS = kmj_pkg::KMJ_KEY_ROWS
) (
    input  kmj_pkg::t_kmj_cmd i_cmd,
    input  logic [7:0]        i_matrix [KEY_ROWS],
    input  logic [7:0]        i_port_a,
    input  logic [7:0]        i_port_b,
    output logic [7:0]        o_read_data
);
    import kmj_pkg::*;

    localparam logic [3:0] ROW_LIMIT = 4'(KEY_ROWS);

    logic [2:0] scan_row;
    logic       row_ok;
    logic [7:0] row_bits;
    logic [7:0] cols;
    logic [2:0] low_col;
    logic [7:0] bus_data;
    logic [7:0] p2_data;

    assign scan_row = i_cmd.p2_value[2:0];
    assign row_ok   = {1'b0, scan_row} < ROW_LIMIT;

    // Row select for the scan
    always_comb begin
        row_bits = PORT_IDLE;
        for (int g = 0; g < KEY_ROWS; g++) begin
            if (scan_row == 3'(g)) begin
                row_bits = i_matrix[g];
            end
        end
    end

    assign cols = ~row_bits;

    // Lowest pressed column
    always_comb begin
        low_col = '0;
        for (int i = 7; i >= 0; i--) begin
            if (cols[i]) begin
                low_col = 3'(i);
            end
        end
    end

    // Bus read: joystick port, enabled by p1 bits 4:3
    always_comb begin
        if (i_cmd.p1_value[4] && i_cmd.p1_value[3]) begin
            bus_data = (scan_row == 3'd1) ? i_port_a : i_port_b;
        end else begin
            bus_data = PORT_IDLE;
        end
    end

    // P2 read: keyboard scan unless p1 bit 2 masks it
    always_comb begin
        if (i_cmd.p1_value[2]) begin
            p2_data = i_cmd.p2_value | 8'hF0;
        end else if (row_ok && (|cols)) begin
            p2_data = {~low_col, 1'b0, i_cmd.p2_value[3:0]};
        end else begin
            p2_data = {4'hF, i_cmd.p2_value[3:0]};
        end
    end

    assign o_read_data = (i_cmd.operation == OP_BUS_READ) ? bus_data : p2_data;

endmodule

// ===== rtl/keyboard_matrix_and_joystick_ports.sv =====
// Keyboard matrix and joystick ports: top level with state and handshake.
//
//   Channel  Dir  Payload                        Transfer
//   i_cmd    in   t_kmj_cmd (op, key, port, p1/p2) valid & ready
//   o_rsp    out  read_data [7:0]                valid & ready
//
// One command per cycle while the response side is not stalled: a command
// is held in the input register, where its write or read is done, and a
// read result lands in the output register, from which it is offered.
// Synchronous active-low reset: all keys and both ports released (0xFF).
// A stalled response holds the input register; writes and unused codes yield none.
module keyboard_matrix_and_joystick_ports #(
    parameter int KEY_ROWS = kmj_pkg::KMJ_KEY_ROWS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    kmj_cmd_if.sink    i_cmd,
    kmj_rsp_if.source  o_rsp
);
    import kmj_pkg::*;

    logic       r_in_valid;
    t_kmj_cmd   r_in;
    logic       r_out_valid;
    logic [7:0] r_out_data;
    logic [7:0] r_matrix [KEY_ROWS];
    logic [7:0] n_matrix [KEY_ROWS];
    logic [7:0] r_port_a;
    logic [7:0] r_port_b;
    logic [7:0] n_port_a;
    logic [7:0] n_port_b;

    t_kmj_op    op;
    t_kmj_key   char_key;
    logic       advance;
    logic       is_read;
    logic [7:0] read_data;
    logic [7:0] bit_mask;
    logic [7:0] port_cur;
    logic [7:0] port_new;

    assign op       = t_kmj_op'(r_in.operation);
    assign char_key = kmj_char_key(r_in.char_code);
    assign is_read  = (op == OP_BUS_READ) || (op == OP_P2_READ);

    // Stage moves when the output register is free or being drained
    assign advance     = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_cmd.ready = !r_in_valid || advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_cmd.ready) begin
            r_in_valid <= i_cmd.valid;
        end
        if (i_cmd.ready && i_cmd.valid) begin
            r_in <= i_cmd.payload;
        end
    end

    // Key matrix next state, one row at a time
    always_comb begin
        for (int g = 0; g < KEY_ROWS; g++) begin
            n_matrix[g] = r_matrix[g];
            if (op == OP_SET_KEY && r_in.key_row == 8'(g) && r_in.key_column[7:3] == 5'd0) begin
                n_matrix[g] = r_in.pressed
                    ? (r_matrix[g] & ~(8'd1 << r_in.key_column[2:0]))
                    : (r_matrix[g] |  (8'd1 << r_in.key_column[2:0]));
            end else if (op == OP_SET_CHAR && char_key.hit && char_key.row == 3'(g)) begin
                n_matrix[g] = r_in.pressed
                    ? (r_matrix[g] & ~(8'd1 << char_key.col))
                    : (r_matrix[g] |  (8'd1 << char_key.col));
            end
        end
    end

    // Joystick port next state
    always_comb begin
        bit_mask = 8'd1 << r_in.bit_index;
        port_cur = r_in.port_select ? r_port_b : r_port_a;
        port_new = port_cur;
        case (op)
            OP_LOAD_PORT: port_new = r_in.port_value;
            OP_SET_BIT:   port_new = r_in.pressed ? (port_cur & ~bit_mask)
                                                  : (port_cur | bit_mask);
            default:      port_new = port_cur;
        endcase
        n_port_a = r_in.port_select ? r_port_a : port_new;
        n_port_b = r_in.port_select ? port_new : r_port_b;
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int g = 0; g < KEY_ROWS; g++) begin
                r_matrix[g] <= PORT_IDLE;
            end
            r_port_a <= PORT_IDLE;
            r_port_b <= PORT_IDLE;
        end else if (advance) begin
            for (int g = 0; g < KEY_ROWS; g++) begin
                r_matrix[g] <= n_matrix[g];
            end
            r_port_a <= n_port_a;
            r_port_b <= n_port_b;
        end
    end

    kmj_read #(
        .KEY_ROWS (KEY_ROWS)
    ) u_read (
        .i_cmd       (r_in),
        .i_matrix    (r_matrix),
        .i_port_a    (r_port_a),
        .i_port_b    (r_port_b),
        .o_read_data (read_data)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= is_read;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
        if (advance && is_read) begin
            r_out_data <= read_data;
        end
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.read_data = r_out_data;

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the keyboard matrix and joystick ports block.
`timescale 1ns / 100ps

import kmj_pkg::*;

// Tracks key matrix and joystick port state and checks read results in order
class kmj_scoreboard;
    logic [7:0] key_rows [KMJ_KEY_ROWS];
    logic [7:0] joy_a;
    logic [7:0] joy_b;
    logic [7:0] expected_reads [$];
    int         mismatches;

    function new();
        foreach (key_rows[r]) key_rows[r] = PORT_IDLE;
        joy_a      = PORT_IDLE;
        joy_b      = PORT_IDLE;
        mismatches = 0;
    endfunction

    function int pending();
        return expected_reads.size();
    endfunction

    // press clears the bit, release sets it (active low)
    function logic [7:0] apply_bit(logic [7:0] v, logic [2:0] idx, logic press);
        logic [7:0] m;
        m = 8'h01 << idx;
        return press ? (v & ~m) : (v | m);
    endfunction

    // Case-folded ASCII code to row*8+column, -1 when unmapped
    function int char_position(logic [7:0] code);
        logic [7:0] c;
        c = code;
        if (c >= 8'h61 && c <= 8'h7A) c = c - 8'h20;
        if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
        case (c)
            8'h20: return 12;   // space
            8'h3F: return 13;
            8'h4C: return 14;
            8'h50: return 15;
            8'h2B: return 16;
            8'h57: return 17;
            8'h45: return 18;
            8'h52: return 19;
            8'h54: return 20;
            8'h55: return 21;
            8'h49: return 22;
            8'h4F: return 23;
            8'h51: return 24;
            8'h53: return 25;
            8'h44: return 26;
            8'h46: return 27;
            8'h47: return 28;
            8'h48: return 29;
            8'h4A: return 30;
            8'h4B: return 31;
            8'h41: return 32;
            8'h5A: return 33;
            8'h58: return 34;
            8'h43: return 35;
            8'h56: return 36;
            8'h42: return 37;
            8'h4D: return 38;
            8'h2E: return 39;
            8'h2D: return 40;
            8'h2A: return 41;
            8'h2F: return 42;
            8'h3D: return 43;
            8'h59: return 44;
            8'h4E: return 45;
            8'h7F: return 46;   // delete
            8'h0A, 8'h0D: return 47;   // line feed / carriage return
            default: return -1;
        endcase
    endfunction

    function void press_key(int row, int col, logic press);
        if (row < KMJ_KEY_ROWS && col < 8)
            key_rows[row] = apply_bit(key_rows[row], 3'(col), press);
    endfunction

    // Update state for an accepted command; queue the byte a read returns
    function void note_command(t_kmj_cmd c);
        int         pos;
        int         i;
        logic [7:0] res;
        case (c.operation)
            OP_SET_KEY: begin
                press_key(int'(c.key_row), int'(c.key_column), c.pressed);
            end
            OP_SET_CHAR: begin
                pos = char_position(c.char_code);
                if (pos >= 0) press_key(pos / 8, pos % 8, c.pressed);
            end
            OP_LOAD_PORT: begin
                if (c.port_select) joy_b = c.port_value;
                else joy_a = c.port_value;
            end
            OP_SET_BIT: begin
                if (c.port_select) joy_b = apply_bit(joy_b, c.bit_index, c.pressed);
                else joy_a = apply_bit(joy_a, c.bit_index, c.pressed);
            end
            OP_BUS_READ: begin
                if (c.p1_value[4:3] == 2'b11)
                    res = (c.p2_value[2:0] == 3'd1) ? joy_a : joy_b;
                else
                    res = PORT_IDLE;
                expected_reads.push_back(res);
            end
            OP_P2_READ: begin
                if (c.p1_value[2]) begin
                    res = c.p2_value | 8'hF0;
                end else begin
                    res = {4'hF, c.p2_value[3:0]};
                    if (int'(c.p2_value[2:0]) < KMJ_KEY_ROWS) begin
                        // walk down so the lowest pressed column wins
                        for (i = 7; i >= 0; i--) begin
                            if (!key_rows[c.p2_value[2:0]][i])
                                res = {~3'(i), 1'b0, c.p2_value[3:0]};
                        end
                    end
                end
                expected_reads.push_back(res);
            end
            default: ;
        endcase
    endfunction

    function void check_read(logic [7:0] got);
        logic [7:0] exp_data;
        if (expected_reads.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected read result %02h", got);
            return;
        end
        exp_data = expected_reads.pop_front();
        if (got !== exp_data) begin
            mismatches++;
            if (mismatches <= 10)
                $display("read_data mismatch: expected %02h, got %02h", exp_data, got);
        end
    endfunction
endclass

module testbench;

    localparam int RANDOM_ITEMS     = 790;
    localparam int PRESSURE_AT      = 300;
    localparam int PRESSURE_READS   = 30;
    localparam int PAUSE_AT         = 600;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int DRAIN_CYCLES     = 8;

    // codes outside the operation set, expected to do nothing
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    logic i_clk;
    logic i_rst_n;
    int   hold_asks;
    int   quiet_cycles;

    kmj_cmd_if cmd_ch ();
    kmj_rsp_if rsp_ch ();

    kmj_scoreboard sb = new();

    keyboard_matrix_and_joystick_ports DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_rsp   (rsp_ch)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Transfer monitor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n && cmd_ch.valid && cmd_ch.ready) sb.note_command(cmd_ch.payload);
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) sb.check_read(rsp_ch.read_data);
        if (!i_rst_n || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("keyboard_matrix_and_joystick_ports test failed");
                $finish;
            end
        end
    end

    // Response side: segments of random stall patterns, plus long hold-offs on request
    initial begin
        int mode;
        int seg_left;
        int hold_left;
        int hold_seen;
        mode      = 0;
        seg_left  = 0;
        hold_left = 0;
        hold_seen = 0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (seg_left == 0) begin
                mode     = $urandom_range(0, 3);
                seg_left = $urandom_range(10, 120);
            end
            seg_left--;
            if (hold_seen != hold_asks) begin
                hold_seen = hold_asks;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end else begin
                case (mode)
                    0: rsp_ch.ready <= 1'b1;
                    1: rsp_ch.ready <= 1'($urandom_range(0, 1));
                    2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: rsp_ch.ready <= (seg_left % 5 != 0);
                endcase
            end
        end
    end

    function automatic t_kmj_cmd make_cmd(logic [2:0] op, logic [7:0] row, logic [7:0] col,
                                          logic [7:0] ch, logic press, logic sel,
                                          logic [7:0] pval, logic [2:0] bidx,
                                          logic [7:0] p1, logic [7:0] p2);
        t_kmj_cmd c;
        c.operation   = op;
        c.key_row     = row;
        c.key_column  = col;
        c.char_code   = ch;
        c.pressed     = press;
        c.port_select = sel;
        c.port_value  = pval;
        c.bit_index   = bidx;
        c.p1_value    = p1;
        c.p2_value    = p2;
        return c;
    endfunction

    function automatic logic [7:0] special_char();
        case ($urandom_range(0, 10))
            0: return 8'h20;
            1: return 8'h3F;
            2: return 8'h2B;
            3: return 8'h2E;
            4: return 8'h2D;
            5: return 8'h2A;
            6: return 8'h2F;
            7: return 8'h3D;
            8: return 8'h7F;
            9: return 8'h0A;
            default: return 8'h0D;
        endcase
    endfunction

    // Mostly in-range keys and mapped characters, with some out-of-range noise
    function automatic t_kmj_cmd random_command();
        t_kmj_cmd c;
        int       pick;
        c = make_cmd(OP_SET_KEY, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), ($urandom_range(0, 99) < 55),
                     1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                     3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)));
        if ($urandom_range(0, 99) < 85) c.key_row = 8'($urandom_range(0, KMJ_KEY_ROWS - 1));
        if ($urandom_range(0, 99) < 85) c.key_column = 8'($urandom_range(0, 7));
        case ($urandom_range(0, 9))
            0, 1, 2: ;
            3, 4:    c.char_code = 8'($urandom_range(8'h30, 8'h39));
            5, 6:    c.char_code = 8'($urandom_range(8'h41, 8'h5A));
            7, 8:    c.char_code = 8'($urandom_range(8'h61, 8'h7A));
            default: c.char_code = special_char();
        endcase
        case ($urandom_range(0, 3))
            1: c.p1_value = (c.p1_value | 8'h18) & ~8'h04;
            2: c.p1_value = c.p1_value & ~8'h04;
            default: ;
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 20)      c.operation = OP_SET_KEY;
        else if (pick < 40) c.operation = OP_SET_CHAR;
        else if (pick < 48) c.operation = OP_LOAD_PORT;
        else if (pick < 58) c.operation = OP_SET_BIT;
        else if (pick < 72) c.operation = OP_BUS_READ;
        else if (pick < 97) c.operation = OP_P2_READ;
        else                c.operation = $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
        return c;
    endfunction

    // Offer one command and hold it until the transfer
    task automatic send_command(t_kmj_cmd c);
        cmd_ch.valid   <= 1'b1;
        cmd_ch.payload <= c;
        do @(posedge i_clk); while (cmd_ch.ready !== 1'b1);
    endtask

    task automatic idle_gap(int n);
        cmd_ch.valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        cmd_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Reset, directed commands, random bursts, drain, verdict
    initial begin
        t_kmj_cmd c;
        int       n;
        int       burst_left;
        cmd_ch.valid   <= 1'b0;
        cmd_ch.payload <= '0;
        i_rst_n        <= 1'b0;
        hold_asks      <= 0;
        burst_left     = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reads straight out of reset
        send_command(make_cmd(OP_BUS_READ, 0, 0, 0, 0, 0, 0, 0, 8'h18, 8'h01));
        send_command(make_cmd(OP_P2_READ, 0, 0, 0, 0, 0, 0, 0, 8'h00, 8'h00));
        // matrix corners and out-of-range positions
        send_command(make_cmd(OP_SET_KEY, 0, 0, 0, 1, 0, 0, 0, 0, 0));
        send_command(make_cmd(OP_SET_KEY, 5, 7, 0, 1, 0, 0, 0, 0, 0));
        send_command(make_cmd(OP_SET_KEY, 6, 0, 0, 1, 0, 0, 0, 0, 0));
        send_command(make_cmd(OP_SET_KEY, 8'hFF, 8'hFF, 0, 1, 0, 0, 0, 0, 0));
        send_command(make_cmd(OP_SET_KEY, 0, 8, 0, 1, 0, 0, 0, 0, 0));
        // row scans: pressed rows, empty row beyond the matrix, bypass by p1 bit 2
        send_command(make_cmd(OP_P2_READ, 0, 0, 0, 0, 0, 0, 0, 8'h00, 8'h08));
        send_command(make_cmd(OP_P2_READ, 0, 0, 0, 0, 0, 0, 0, 8'h00, 8'hF5));
        send_command(make_cmd(OP_P2_READ, 0, 0, 0, 0, 0, 0, 0, 8'h00, 8'h06));
        send_command(make_cmd(OP_P2_READ, 0, 0, 0, 0, 0, 0, 0, 8'h00, 8'hFF));
        send_command(make_cmd(OP_P2_READ, 0, 0, 0, 0, 0, 0, 0, 8'h04, 8'h0A));
        // character map: case fold, delete, line ending, unmapped codes
        send_command(make_cmd(OP_SET_CHAR, 0, 0, 8'h61, 1, 0, 0, 0, 0, 0));
        send_command(make_cmd(OP_SET_CHAR, 0, 0, 8'h7F, 1, 0, 0, 0, 0, 0));
        send_command(make_cmd(OP_SET_CHAR, 0, 0, 8'h0D, 1, 0, 0, 0, 0, 0));
        send_command(make_cmd(OP_SET_CHAR, 0, 0, 8'h0A, 0, 0, 0, 0, 0, 0));
        send_command(make_cmd(OP_SET_CHAR, 0, 0, 8'h80, 1, 0, 0, 0, 0, 0));
        send_command(make_cmd(OP_SET_CHAR, 0, 0, 8'hFF, 1, 0, 0, 0, 0, 0));
        send_command(make_cmd(OP_P2_READ, 0, 0, 0, 0, 0, 0, 0, 8'h00, 8'h04));
        // joystick ports
        send_command(make_cmd(OP_LOAD_PORT, 0, 0, 0, 0, 0, 8'h00, 0, 0, 0));
        send_command(make_cmd(OP_LOAD_PORT, 0, 0, 0, 0, 1, 8'hAA, 0, 0, 0));
        send_command(make_cmd(OP_SET_BIT, 0, 0, 0, 0, 0, 0, 3'd7, 0, 0));
        send_command(make_cmd(OP_SET_BIT, 0, 0, 0, 1, 1, 0, 3'd7, 0, 0));
        send_command(make_cmd(OP_BUS_READ, 0, 0, 0, 0, 0, 0, 0, 8'hFF, 8'hF9));
        send_command(make_cmd(OP_BUS_READ, 0, 0, 0, 0, 0, 0, 0, 8'h18, 8'h00));
        send_command(make_cmd(OP_BUS_READ, 0, 0, 0, 0, 0, 0, 0, 8'h10, 8'h01));
        send_command(make_cmd(OP_BUS_READ, 0, 0, 0, 0, 0, 0, 0, 8'h08, 8'h01));
        send_command(make_cmd(OP_SPARE_6, 0, 0, 0, 1, 0, 0, 0, 8'h18, 8'h01));
        send_command(make_cmd(OP_SPARE_7, 0, 0, 0, 1, 1, 0, 0, 0, 0));

        // random bursts with gaps
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == PRESSURE_AT) begin
                // response side holds off while reads keep coming
                hold_asks <= hold_asks + 1;
                repeat (PRESSURE_READS) begin
                    c = random_command();
                    c.operation = $urandom_range(0, 1) ? OP_BUS_READ : OP_P2_READ;
                    send_command(c);
                end
            end
            if (n == PAUSE_AT) wait_drained();
            if (burst_left == 0) begin
                idle_gap($urandom_range(1, 12));
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                         : $urandom_range(1, 20);
            end
            send_command(random_command());
            burst_left--;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("keyboard_matrix_and_joystick_ports test passed");
        else
            $display("keyboard_matrix_and_joystick_ports test failed");
        $finish;
    end

endmodule
